// ===== src/meter_response_frame_checker_unit_defines.svh =====
// Assertion macros shared by the frame checker modules.
`ifndef METER_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH
`define METER_RESPONSE_FRAME_CHECKER_UNIT_DEFINES_SVH

// Property that must hold in the same cycle as its trigger.
`define MRFC_ASSERT_NOW(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Property that must hold in the cycle after its trigger.
`define MRFC_ASSERT_NEXT(label, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== src/mrfc_pkg.sv =====
// Types and constants shared by the meter response frame checker.
package mrfc_pkg;

	// Frame marks and code values.
	localparam logic [7:0] START_MARK  = 8'h68;
	localparam logic [7:0] END_MARK    = 8'h16;
	localparam logic [7:0] CTRL_MASK   = 8'hdf;
	localparam logic [7:0] CTRL_READ   = 8'h81;
	localparam logic [7:0] CTRL_WRITE  = 8'h84;
	localparam logic [7:0] DATA_OFFSET = 8'h33;
	localparam logic [8:0] COUNT_MAX   = 9'd511;

	// Byte positions within the frame.
	localparam logic [8:0] POS_START0 = 9'd0;
	localparam logic [8:0] POS_START1 = 9'd7;
	localparam logic [8:0] POS_CTRL   = 9'd8;
	localparam logic [8:0] POS_LEN    = 9'd9;
	localparam logic [8:0] POS_ITEM0  = 9'd10;
	localparam logic [8:0] POS_ITEM1  = 9'd11;
	localparam logic [8:0] POS_DATA   = 9'd12;

	// Minimum frame sizes for each mode.
	localparam logic [8:0] MIN_READ  = 9'd14;
	localparam logic [8:0] MIN_WRITE = 9'd11;

	// Configuration register indexes.
	localparam logic [1:0] REG_ADDRESS = 2'd0;
	localparam logic [1:0] REG_ITEM    = 2'd1;
	localparam logic [1:0] REG_MODE    = 2'd2;

	// Status codes.
	localparam logic [3:0] ST_OK      = 4'd0;
	localparam logic [3:0] ST_SHORT   = 4'd1;
	localparam logic [3:0] ST_HEADER  = 4'd2;
	localparam logic [3:0] ST_ADDRESS = 4'd3;
	localparam logic [3:0] ST_CONTROL = 4'd4;
	localparam logic [3:0] ST_ITEM    = 4'd5;
	localparam logic [3:0] ST_LENGTH  = 4'd6;
	localparam logic [3:0] ST_SUM     = 4'd7;
	localparam logic [3:0] ST_END     = 4'd8;

	// Check mode values.
	localparam logic MODE_READ  = 1'b0;
	localparam logic MODE_WRITE = 1'b1;

	typedef struct packed {
		logic [47:0] address;
		logic [15:0] item;
		logic        mode;
	} cfg_t;

	typedef struct packed {
		logic end_bad;
		logic sum_bad;
		logic item_bad;
		logic ctrl_wr_bad;
		logic ctrl_rd_bad;
		logic addr_bad;
		logic hdr_bad;
	} flags_t;

	// One queued result: a decoded payload byte or a frame summary.
	typedef struct packed {
		logic        is_status;
		logic [7:0]  data;
		flags_t      flags;
		logic [8:0]  count;
		logic [7:0]  length;
		logic        read_mode;
	} entry_t;

endpackage

// ===== src/mrfc_channels.sv =====
// Channel interfaces for the frame checker: byte input, result output and register writes.
interface mrfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	logic       last_byte;

	modport source (output valid, output rx_byte, output last_byte, input ready);
	modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

interface mrfc_out_if;
	logic       valid;
	logic       ready;
	logic       is_status;
	logic [7:0] payload_byte;
	logic [3:0] status_code;
	logic [7:0] payload_length;

	modport source (output valid, output is_status, output payload_byte,
		output status_code, output payload_length, input ready);
	modport sink (input valid, input is_status, input payload_byte,
		input status_code, input payload_length, output ready);
endinterface

interface mrfc_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  reg_index;
	logic [47:0] reg_data;

	modport source (output valid, output reg_index, output reg_data, input ready);
	modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

// ===== src/mrfc_front.sv =====
// Front end: classifies each received byte, tracks frame state and queues results.
`include "meter_response_frame_checker_unit_defines.svh"

module mrfc_front (
	input  logic            clk,
	input  logic            arst_n,
	input  mrfc_pkg::cfg_t  cfg,
	input  logic            accept,
	input  logic [7:0]      rx_byte,
	input  logic            last_byte,
	output logic            push,
	output mrfc_pkg::entry_t push_entry
);

	logic [8:0]       count_q;
	logic [7:0]       len_q;
	logic [7:0]       sum_q;
	logic [7:0]       item_low_q;
	mrfc_pkg::flags_t flags_q;

	logic [8:0]       count_next;
	logic [7:0]       len_next;
	logic [7:0]       sum_next;
	logic [7:0]       item_low_next;
	mrfc_pkg::flags_t flags_next;
	logic [7:0]       decoded;
	logic [7:0]       addr_byte;
	logic [2:0]       addr_sel;
	logic [9:0]       pos_sum;
	logic             in_body;
	logic             emit;

	assign decoded  = rx_byte - mrfc_pkg::DATA_OFFSET;
	assign addr_sel = count_q[2:0] - 3'd1;
	assign addr_byte = cfg.address[{addr_sel, 3'b000} +: 8];
	assign pos_sum  = {2'b00, len_q} + 10'd10;
	assign in_body  = (count_q < mrfc_pkg::POS_ITEM0) || ({1'b0, count_q} < pos_sum);

	// Per-byte checks by position in the frame.
	always_comb begin
		flags_next    = flags_q;
		len_next      = len_q;
		sum_next      = sum_q;
		item_low_next = item_low_q;
		emit          = 1'b0;
		if (count_q == mrfc_pkg::POS_START0 || count_q == mrfc_pkg::POS_START1) begin
			if (rx_byte != mrfc_pkg::START_MARK) flags_next.hdr_bad = 1'b1;
		end else if (count_q >= 9'd1 && count_q <= 9'd6) begin
			if (addr_byte != rx_byte) flags_next.addr_bad = 1'b1;
		end else if (count_q == mrfc_pkg::POS_CTRL) begin
			if ((rx_byte & mrfc_pkg::CTRL_MASK) != mrfc_pkg::CTRL_READ)
				flags_next.ctrl_rd_bad = 1'b1;
			if ((rx_byte & mrfc_pkg::CTRL_MASK) != mrfc_pkg::CTRL_WRITE)
				flags_next.ctrl_wr_bad = 1'b1;
		end else if (count_q == mrfc_pkg::POS_LEN) begin
			len_next = rx_byte;
		end
		if (count_q == mrfc_pkg::POS_ITEM0) item_low_next = decoded;
		if (count_q == mrfc_pkg::POS_ITEM1) begin
			if ({decoded, item_low_q} != cfg.item) flags_next.item_bad = 1'b1;
		end
		// Checksum covers the header and the data field; the two bytes after it close the frame.
		if (in_body) begin
			sum_next = sum_q + rx_byte;
			if (count_q >= mrfc_pkg::POS_DATA && cfg.mode == mrfc_pkg::MODE_READ) emit = 1'b1;
		end else if ({1'b0, count_q} == pos_sum) begin
			if (rx_byte != sum_q) flags_next.sum_bad = 1'b1;
		end else if ({1'b0, count_q} == pos_sum + 10'd1) begin
			if (rx_byte != mrfc_pkg::END_MARK) flags_next.end_bad = 1'b1;
		end
		count_next = (count_q < mrfc_pkg::COUNT_MAX) ? count_q + 9'd1 : count_q;
	end

	// Result word toward the queue.
	always_comb begin
		push                 = accept && (last_byte || emit);
		push_entry.is_status = last_byte;
		push_entry.data      = last_byte ? 8'h00 : decoded;
		push_entry.flags     = flags_next;
		push_entry.count     = count_next;
		push_entry.length    = len_next;
		push_entry.read_mode = (cfg.mode == mrfc_pkg::MODE_READ);
	end

	// Frame state; the last byte returns everything to the start of a frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			item_low_q <= '0;
			flags_q    <= '0;
		end else if (accept) begin
			if (last_byte) begin
				count_q    <= '0;
				len_q      <= '0;
				sum_q      <= '0;
				item_low_q <= '0;
				flags_q    <= '0;
			end else begin
				count_q    <= count_next;
				len_q      <= len_next;
				sum_q      <= sum_next;
				item_low_q <= item_low_next;
				flags_q    <= flags_next;
			end
		end
	end

	`MRFC_ASSERT_NEXT(a_last_clears, accept && last_byte,
		count_q == 9'd0 && flags_q == '0, "frame state not cleared after last byte")
	`MRFC_ASSERT_NOW(a_payload_pos, push && !last_byte,
		count_q >= mrfc_pkg::POS_DATA && cfg.mode == mrfc_pkg::MODE_READ,
		"payload released outside the data field")
	`MRFC_ASSERT_NOW(a_push_needs_accept, push, accept, "result queued without an accepted byte")

endmodule

// ===== src/mrfc_queue.sv =====
// Short result queue between the front end and the output stage.
`include "meter_response_frame_checker_unit_defines.svh"

module mrfc_queue #(
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mrfc_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output logic             empty,
	output mrfc_pkg::entry_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] DEPTH_C  = CW'(DEPTH);

	mrfc_pkg::entry_t slots_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    fill_q;

	assign full  = (fill_q == DEPTH_C);
	assign empty = (fill_q == '0);
	assign head  = slots_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) slots_q[wr_ptr_q] <= push_entry;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) fill_q <= fill_q + 1'b1;
			else if (pop && !push) fill_q <= fill_q - 1'b1;
		end
	end

	`MRFC_ASSERT_NOW(a_no_overflow, push, !full, "push into a full queue")
	`MRFC_ASSERT_NOW(a_no_underflow, pop, !empty, "pop from an empty queue")
	`MRFC_ASSERT_NOW(a_fill_bound, 1'b1, fill_q <= DEPTH_C, "queue fill level out of range")

endmodule

// ===== src/mrfc_back.sv =====
// Output stage: resolves the frame status and holds the result word for the consumer.
module mrfc_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             empty,
	input  mrfc_pkg::entry_t head,
	output logic             pop,
	mrfc_out_if.source       tx
);

	logic       valid_q;
	logic       is_status_q;
	logic [7:0] payload_q;
	logic [3:0] status_q;
	logic [7:0] plen_q;

	logic [3:0] status_d;
	logic [7:0] plen_d;
	logic [9:0] need_len;
	logic [8:0] min_len;

	assign need_len = {2'b00, head.length} + 10'd12;
	assign min_len  = head.read_mode ? mrfc_pkg::MIN_READ : mrfc_pkg::MIN_WRITE;

	// First failure in priority order.
	always_comb begin
		plen_d = 8'h00;
		if (head.count < min_len) status_d = mrfc_pkg::ST_SHORT;
		else if (head.flags.hdr_bad) status_d = mrfc_pkg::ST_HEADER;
		else if (head.flags.addr_bad) status_d = mrfc_pkg::ST_ADDRESS;
		else if (head.read_mode ? head.flags.ctrl_rd_bad : head.flags.ctrl_wr_bad)
			status_d = mrfc_pkg::ST_CONTROL;
		else if (head.read_mode && head.flags.item_bad) status_d = mrfc_pkg::ST_ITEM;
		else if ((head.read_mode && head.length < 8'd2) || ({1'b0, head.count} < need_len))
			status_d = mrfc_pkg::ST_LENGTH;
		else if (head.flags.sum_bad) status_d = mrfc_pkg::ST_SUM;
		else if (head.flags.end_bad) status_d = mrfc_pkg::ST_END;
		else begin
			status_d = mrfc_pkg::ST_OK;
			if (head.read_mode) plen_d = head.length - 8'd2;
		end
	end

	assign pop = !empty && (!valid_q || tx.ready);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (tx.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			is_status_q <= head.is_status;
			payload_q   <= head.data;
			status_q    <= head.is_status ? status_d : mrfc_pkg::ST_OK;
			plen_q      <= head.is_status ? plen_d : 8'h00;
		end
	end

	assign tx.valid          = valid_q;
	assign tx.is_status      = is_status_q;
	assign tx.payload_byte   = payload_q;
	assign tx.status_code    = status_q;
	assign tx.payload_length = plen_q;

endmodule

// ===== src/meter_response_frame_checker_unit.sv =====
// Top level of the meter response frame checker: registers, front end, queue and output stage.
//
//  channel  dir  word                                               flow
//  cfg      in   reg_index, reg_data                                 valid/ready, ready held high
//  rx       in   rx_byte, last_byte                                  valid/ready
//  tx       out  is_status, payload_byte, status_code, payload_length valid/ready
//
// One byte is accepted per cycle while the queue has room; a result passes through a queue
// slot and then the output register.
// arst_n clears the frame state, the queue pointers, the output valid and the configuration registers.
// A stalled tx fills the queue of QUEUE_DEPTH words, after which rx ready drops.
// Bytes that cause no result never wait on tx while the queue has room.
module meter_response_frame_checker_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	mrfc_cfg_if.sink   cfg,
	mrfc_in_if.sink    rx,
	mrfc_out_if.source tx
);

	mrfc_pkg::cfg_t   cfg_q;
	logic             accept;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	mrfc_pkg::entry_t push_entry;
	mrfc_pkg::entry_t head;

	// Register writes.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.reg_index)
				mrfc_pkg::REG_ADDRESS: cfg_q.address <= cfg.reg_data;
				mrfc_pkg::REG_ITEM:    cfg_q.item    <= cfg.reg_data[15:0];
				mrfc_pkg::REG_MODE:    cfg_q.mode    <= cfg.reg_data[0];
				default: ;
			endcase
		end
	end

	assign rx.ready = !full;
	assign accept   = rx.valid && !full;

	mrfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.accept     (accept),
		.rx_byte    (rx.rx_byte),
		.last_byte  (rx.last_byte),
		.push       (push),
		.push_entry (push_entry)
	);

	mrfc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.empty      (empty),
		.head       (head)
	);

	mrfc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.tx     (tx)
	);

endmodule

// ===== sim/meter_response_frame_checker_unit_tb.sv =====
// Testbench for the meter response frame checker: framed byte traffic against a cycle-free predictor.
module meter_response_frame_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Offsets added to the length value to give the checksum position, the end mark position and the full frame size.
	localparam int SUM_AT   = 10;
	localparam int END_AT   = 11;
	localparam int LEN_TAIL = 12;
	// Register index that maps to no register.
	localparam logic [1:0] REG_UNUSED = 2'd3;
	// Cycles allowed for the pipeline and result queue to drain after the last result.
	localparam int QUIET_CYCLES = 16;
	localparam int MAX_REPORTS  = 10;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic       is_status;
		logic [7:0] payload_byte;
		logic [3:0] status_code;
		logic [7:0] payload_length;
	} frame_result_t;

	typedef enum int {
		FAULT_FLIP,
		FAULT_TRUNC,
		FAULT_TRAIL,
		FAULT_CTRL
	} fault_t;

	logic clk = 1'b0;
	logic arst_n;

	mrfc_cfg_if cfg_bus ();
	mrfc_in_if  rx_bus ();
	mrfc_out_if tx_bus ();

	meter_response_frame_checker_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_bus),
		.rx     (rx_bus),
		.tx     (tx_bus)
	);

	// Shadow registers and frame state of the predictor.
	mrfc_pkg::cfg_t   shadow_cfg  = '0;
	logic [8:0]       rx_count    = '0;
	logic [7:0]       rx_len      = '0;
	logic [7:0]       rx_sum      = '0;
	logic [7:0]       rx_item_lo  = '0;
	mrfc_pkg::flags_t rx_flags    = '0;

	frame_result_t pending_results[$];
	int            fail_count    = 0;
	int            sent_bytes    = 0;
	int            src_idle_pct  = 0;
	int            snk_stall_pct = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard limit on the run time.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic void report_error(input string msg);
		fail_count++;
		if (fail_count <= MAX_REPORTS) $display("%0t ns: %s", $realtime, msg);
	endfunction

	// Update the frame state with one accepted byte and queue the result it causes.
	function automatic void track_rx_byte(input logic [7:0] b, input logic last);
		int i;
		logic emit;
		logic rd;
		logic [7:0] hi;
		frame_result_t r;
		i = int'(rx_count);
		emit = 1'b0;
		r = '0;
		if (i == mrfc_pkg::POS_START0 || i == mrfc_pkg::POS_START1) begin
			if (b != mrfc_pkg::START_MARK) rx_flags.hdr_bad = 1'b1;
		end else if (i >= 1 && i <= 6) begin
			if (shadow_cfg.address[8*(i-1) +: 8] != b) rx_flags.addr_bad = 1'b1;
		end else if (i == mrfc_pkg::POS_CTRL) begin
			if ((b & mrfc_pkg::CTRL_MASK) != mrfc_pkg::CTRL_READ) rx_flags.ctrl_rd_bad = 1'b1;
			if ((b & mrfc_pkg::CTRL_MASK) != mrfc_pkg::CTRL_WRITE) rx_flags.ctrl_wr_bad = 1'b1;
		end else if (i == mrfc_pkg::POS_LEN) begin
			rx_len = b;
		end
		if (i == mrfc_pkg::POS_ITEM0) rx_item_lo = b - mrfc_pkg::DATA_OFFSET;
		if (i == mrfc_pkg::POS_ITEM1) begin
			hi = b - mrfc_pkg::DATA_OFFSET;
			if ({hi, rx_item_lo} != shadow_cfg.item) rx_flags.item_bad = 1'b1;
		end

		// Checksum covers everything before its own position; the end mark follows it and later bytes are ignored.
		if (i < mrfc_pkg::POS_ITEM0 || i < rx_len + SUM_AT) begin
			rx_sum = rx_sum + b;
			emit = (i >= mrfc_pkg::POS_DATA) && (shadow_cfg.mode == mrfc_pkg::MODE_READ);
		end else if (i == rx_len + SUM_AT) begin
			if (b != rx_sum) rx_flags.sum_bad = 1'b1;
		end else if (i == rx_len + END_AT) begin
			if (b != mrfc_pkg::END_MARK) rx_flags.end_bad = 1'b1;
		end

		if (rx_count != mrfc_pkg::COUNT_MAX) rx_count = rx_count + 9'd1;

		if (last) begin
			// First failure in priority order decides the status.
			rd = (shadow_cfg.mode == mrfc_pkg::MODE_READ);
			r.is_status = 1'b1;
			if (rx_count < (rd ? mrfc_pkg::MIN_READ : mrfc_pkg::MIN_WRITE))
				r.status_code = mrfc_pkg::ST_SHORT;
			else if (rx_flags.hdr_bad) r.status_code = mrfc_pkg::ST_HEADER;
			else if (rx_flags.addr_bad) r.status_code = mrfc_pkg::ST_ADDRESS;
			else if (rd ? rx_flags.ctrl_rd_bad : rx_flags.ctrl_wr_bad)
				r.status_code = mrfc_pkg::ST_CONTROL;
			else if (rd && rx_flags.item_bad) r.status_code = mrfc_pkg::ST_ITEM;
			else if ((rd && rx_len < 2) || rx_count < rx_len + LEN_TAIL)
				r.status_code = mrfc_pkg::ST_LENGTH;
			else if (rx_flags.sum_bad) r.status_code = mrfc_pkg::ST_SUM;
			else if (rx_flags.end_bad) r.status_code = mrfc_pkg::ST_END;
			else begin
				r.status_code = mrfc_pkg::ST_OK;
				if (rd) r.payload_length = rx_len - 8'd2;
			end
			pending_results.push_back(r);
			rx_count = '0;
			rx_len = '0;
			rx_sum = '0;
			rx_item_lo = '0;
			rx_flags = '0;
		end else if (emit) begin
			r.payload_byte = b - mrfc_pkg::DATA_OFFSET;
			pending_results.push_back(r);
		end
	endfunction

	// Recompute the checksum byte of a frame that still holds one.
	function automatic void reseal(ref byte_q_t f);
		int pos;
		logic [7:0] s;
		if (f.size() <= mrfc_pkg::POS_LEN) return;
		pos = f[mrfc_pkg::POS_LEN] + SUM_AT;
		if (pos >= f.size()) return;
		s = '0;
		for (int k = 0; k < pos; k++) s = s + f[k];
		f[pos] = s;
	endfunction

	// Well-formed frame for the given mode under the current register settings.
	function automatic byte_q_t build_frame(input logic mode, input logic [7:0] len);
		byte_q_t f;
		logic [7:0] ctl;
		logic rd;
		rd = (mode == mrfc_pkg::MODE_READ);
		f.push_back(mrfc_pkg::START_MARK);
		for (int k = 0; k < 6; k++) f.push_back(shadow_cfg.address[8*k +: 8]);
		f.push_back(mrfc_pkg::START_MARK);
		ctl = rd ? mrfc_pkg::CTRL_READ : mrfc_pkg::CTRL_WRITE;
		// Bit 5 of the control byte is a don't-care.
		if ($urandom_range(1)) ctl = ctl | ~mrfc_pkg::CTRL_MASK;
		f.push_back(ctl);
		f.push_back(len);
		for (int k = 0; k < len; k++) begin
			if (rd && k == 0) f.push_back(shadow_cfg.item[7:0] + mrfc_pkg::DATA_OFFSET);
			else if (rd && k == 1) f.push_back(shadow_cfg.item[15:8] + mrfc_pkg::DATA_OFFSET);
			else f.push_back(8'($urandom_range(255)));
		end
		f.push_back(8'h00);
		f.push_back(mrfc_pkg::END_MARK);
		reseal(f);
		return f;
	endfunction

	function automatic void apply_fault(ref byte_q_t f, input fault_t kind);
		int n;
		case (kind)
			FAULT_FLIP: begin
				n = $urandom_range(f.size() - 1);
				f[n] = f[n] ^ 8'($urandom_range(1, 255));
				if ($urandom_range(1)) reseal(f);
			end
			FAULT_TRUNC: begin
				n = $urandom_range(1, f.size() - 1);
				while (f.size() > n) void'(f.pop_back());
			end
			FAULT_TRAIL: begin
				repeat ($urandom_range(1, 8)) f.push_back(8'($urandom_range(255)));
			end
			FAULT_CTRL: begin
				f[mrfc_pkg::POS_CTRL] = 8'($urandom_range(255));
				reseal(f);
			end
			default: ;
		endcase
	endfunction

	function automatic logic [47:0] rand48();
		logic [47:0] v;
		v[47:32] = 16'($urandom_range(16'hffff));
		v[31:0] = $urandom;
		return v;
	endfunction

	function automatic void set_idling(input int src_pct, input int snk_pct);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
	endfunction

	// Offer one word on rx and wait for it to be taken. Valid stays high for a following word.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			rx_bus.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		rx_bus.valid <= 1'b1;
		rx_bus.rx_byte <= b;
		rx_bus.last_byte <= last;
		do @(posedge clk); while (!rx_bus.ready);
		track_rx_byte(b, last);
		sent_bytes++;
	endtask

	// Send bytes lo..hi-1 of a frame; only the frame's final byte carries the last mark.
	task automatic send_bytes(input byte_q_t f, input int lo, input int hi);
		for (int k = lo; k < hi; k++) send_byte(f[k], k == f.size() - 1);
	endtask

	// Drop rx valid and let every outstanding result drain.
	task automatic wait_idle();
		rx_bus.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	// Register write; only issued while the block is idle.
	task automatic write_reg(input logic [1:0] idx, input logic [47:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.reg_index <= idx;
		cfg_bus.reg_data <= data;
		do @(posedge clk); while (!cfg_bus.ready);
		case (idx)
			mrfc_pkg::REG_ADDRESS: shadow_cfg.address = data;
			mrfc_pkg::REG_ITEM:    shadow_cfg.item = data[15:0];
			mrfc_pkg::REG_MODE:    shadow_cfg.mode = data[0];
			default: ;
		endcase
		cfg_bus.valid <= 1'b0;
		@(posedge clk);
	endtask

	// Result checker and receiver stall generator.
	always @(posedge clk) begin
		frame_result_t got;
		frame_result_t want;
		if (!arst_n) begin
			tx_bus.ready <= 1'b0;
		end else begin
			if (tx_bus.valid && tx_bus.ready) begin
				got.is_status = tx_bus.is_status;
				got.payload_byte = tx_bus.payload_byte;
				got.status_code = tx_bus.status_code;
				got.payload_length = tx_bus.payload_length;
				if (pending_results.size() == 0) begin
					report_error($sformatf("unexpected result word %h", got));
				end else begin
					want = pending_results.pop_front();
					if (got.is_status !== want.is_status
						|| got.payload_byte !== want.payload_byte
						|| got.status_code !== want.status_code
						|| got.payload_length !== want.payload_length) begin
						report_error($sformatf({"result mismatch: is_status %0d/%0d",
							" byte %h/%h status %0d/%0d len %0d/%0d (exp/act)"},
							want.is_status, got.is_status, want.payload_byte,
							got.payload_byte, want.status_code, got.status_code,
							want.payload_length, got.payload_length));
					end
				end
			end
			tx_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
		end
	end

	// Good read frames at the register extremes, including the unused index.
	task automatic test_read_frames();
		byte_q_t f;
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_READ));
		write_reg(mrfc_pkg::REG_ADDRESS, 48'hffff_ffff_ffff);
		write_reg(mrfc_pkg::REG_ITEM, 48'h00_ffff);
		write_reg(REG_UNUSED, rand48());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd4);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_READ;
		f[mrfc_pkg::POS_DATA] = mrfc_pkg::DATA_OFFSET;
		f[mrfc_pkg::POS_DATA + 1] = mrfc_pkg::DATA_OFFSET - 8'd1;
		reseal(f);
		send_bytes(f, 0, f.size());
		wait_idle();
		write_reg(mrfc_pkg::REG_ADDRESS, 48'h0);
		write_reg(mrfc_pkg::REG_ITEM, 48'h0);
		f = build_frame(mrfc_pkg::MODE_READ, 8'd2);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_READ | ~mrfc_pkg::CTRL_MASK;
		reseal(f);
		send_bytes(f, 0, f.size());
		// Bytes past the end mark are ignored.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		repeat (3) f.push_back(8'($urandom_range(255)));
		send_bytes(f, 0, f.size());
	endtask

	// Good write acknowledges; item bytes do not matter in this mode.
	task automatic test_write_frames();
		byte_q_t f;
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_WRITE));
		write_reg(mrfc_pkg::REG_ADDRESS, rand48());
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd0);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_WRITE;
		reseal(f);
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd4);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_WRITE | ~mrfc_pkg::CTRL_MASK;
		f[mrfc_pkg::POS_ITEM1] = f[mrfc_pkg::POS_ITEM1] ^ 8'h5a;
		reseal(f);
		send_bytes(f, 0, f.size());
	endtask

	// Frames for every failure status in read mode, and for the short, control and length statuses in write mode.
	task automatic test_status_codes();
		byte_q_t f;
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_READ));
		write_reg(mrfc_pkg::REG_ADDRESS, rand48());
		write_reg(mrfc_pkg::REG_ITEM, 48'($urandom_range(16'hffff)));
		// Smallest read frame minus its end byte is too short.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd2);
		void'(f.pop_back());
		send_bytes(f, 0, f.size());
		// Bad start marks, and a header error ranking above an address error.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[mrfc_pkg::POS_START0] = 8'h00;
		f[1] = f[1] ^ 8'h01;
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[mrfc_pkg::POS_START1] = 8'h69;
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[6] = f[6] ^ 8'h80;
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_WRITE;
		reseal(f);
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[mrfc_pkg::POS_ITEM1] = f[mrfc_pkg::POS_ITEM1] ^ 8'h01;
		reseal(f);
		send_bytes(f, 0, f.size());
		// Cut inside the payload: the last byte is a payload byte and gives only the status.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd6);
		while (f.size() > 15) void'(f.pop_back());
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[f.size() - 2] = f[f.size() - 2] ^ 8'hff;
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_READ, 8'd3);
		f[f.size() - 1] = 8'h17;
		send_bytes(f, 0, f.size());
		// Length below two in read mode, with the item register matched to the checksum byte.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd1);
		wait_idle();
		write_reg(mrfc_pkg::REG_ITEM, {32'h0, f[mrfc_pkg::POS_ITEM1] - mrfc_pkg::DATA_OFFSET,
			f[mrfc_pkg::POS_ITEM0] - mrfc_pkg::DATA_OFFSET});
		f.push_back(8'($urandom_range(255)));
		send_bytes(f, 0, f.size());
		// Write mode: short, control and length failures.
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_WRITE));
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd0);
		while (f.size() > 10) void'(f.pop_back());
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd2);
		f[mrfc_pkg::POS_CTRL] = mrfc_pkg::CTRL_READ;
		reseal(f);
		send_bytes(f, 0, f.size());
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd3);
		while (f.size() > 13) void'(f.pop_back());
		send_bytes(f, 0, f.size());
	endtask

	// Register changes while a frame is half received.
	task automatic test_midframe_registers();
		byte_q_t f;
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_READ));
		write_reg(mrfc_pkg::REG_ADDRESS, rand48());
		write_reg(mrfc_pkg::REG_ITEM, 48'($urandom_range(16'hffff)));
		// Item bytes arrive in write mode; read mode at the end still judges them.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd5);
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_WRITE));
		send_bytes(f, 0, mrfc_pkg::POS_DATA);
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_READ));
		send_bytes(f, mrfc_pkg::POS_DATA, f.size());
		// Read frame finished in write mode fails on the control byte, no payload released.
		f = build_frame(mrfc_pkg::MODE_READ, 8'd4);
		send_bytes(f, 0, mrfc_pkg::POS_LEN);
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_WRITE));
		send_bytes(f, mrfc_pkg::POS_LEN, f.size());
		// Address register changed after the first address bytes.
		f = build_frame(mrfc_pkg::MODE_WRITE, 8'd2);
		send_bytes(f, 0, 4);
		wait_idle();
		write_reg(mrfc_pkg::REG_ADDRESS, ~shadow_cfg.address);
		send_bytes(f, 4, f.size());
	endtask

	// Longest frame with enough trailing bytes to run the counter into saturation.
	task automatic test_count_saturation();
		byte_q_t f;
		set_idling(27, 27);
		wait_idle();
		write_reg(mrfc_pkg::REG_MODE, 48'(mrfc_pkg::MODE_READ));
		write_reg(mrfc_pkg::REG_ITEM, 48'($urandom_range(16'hffff)));
		f = build_frame(mrfc_pkg::MODE_READ, 8'd255);
		repeat (260) f.push_back(8'($urandom_range(255)));
		send_bytes(f, 0, f.size());
	endtask

	function automatic int pick_len(input logic mode);
		int dice;
		dice = $urandom_range(99);
		if (dice < 3) return $urandom_range(100, 255);
		if (mode == mrfc_pkg::MODE_READ) begin
			if (dice < 11) return $urandom_range(1);
			return $urandom_range(2, 14);
		end
		return $urandom_range(12);
	endfunction

	// Mostly good frames, some faulted ones and a little raw noise.
	task automatic send_random_frame();
		byte_q_t f;
		int dice;
		logic mode;
		dice = $urandom_range(99);
		if (dice < 12) begin
			repeat ($urandom_range(1, 16)) f.push_back(8'($urandom_range(255)));
		end else begin
			mode = ($urandom_range(9) == 0) ? ~shadow_cfg.mode : shadow_cfg.mode;
			f = build_frame(mode, 8'(pick_len(mode)));
			if (dice >= 70) apply_fault(f, fault_t'($urandom_range(FAULT_CTRL)));
		end
		send_bytes(f, 0, f.size());
	endtask

	task automatic test_random_traffic();
		int start_bytes;
		for (int p = 0; p < 8; p++) begin
			case (p / 2)
				0: set_idling(0, 0);
				1: set_idling(75, 0);
				2: set_idling(0, 75);
				default: set_idling(27, 27);
			endcase
			wait_idle();
			case ($urandom_range(3))
				0: write_reg(mrfc_pkg::REG_ADDRESS, 48'h0);
				1: write_reg(mrfc_pkg::REG_ADDRESS, 48'hffff_ffff_ffff);
				default: write_reg(mrfc_pkg::REG_ADDRESS, rand48());
			endcase
			case ($urandom_range(3))
				0: write_reg(mrfc_pkg::REG_ITEM, 48'h0);
				1: write_reg(mrfc_pkg::REG_ITEM, 48'h00_ffff);
				default: write_reg(mrfc_pkg::REG_ITEM, 48'($urandom_range(16'hffff)));
			endcase
			write_reg(mrfc_pkg::REG_MODE,
				48'((p % 2 == 0) ? mrfc_pkg::MODE_READ : mrfc_pkg::MODE_WRITE));
			start_bytes = sent_bytes;
			while (sent_bytes - start_bytes < 16) send_random_frame();
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		rx_bus.valid <= 1'b0;
		rx_bus.rx_byte <= '0;
		rx_bus.last_byte <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.reg_index <= '0;
		cfg_bus.reg_data <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(0, 0);
		test_read_frames();
		test_write_frames();
		test_status_codes();
		test_midframe_registers();
		test_count_saturation();
		test_random_traffic();
		wait_idle();

		if (fail_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule
